>>> design/tlv_nesting_level_tracker_core_macros.svh
// ----------------------------------------------------------------------------
// TLV nesting level tracker - assertion macros
// Shared concurrent assertion forms, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef TLV_NESTING_LEVEL_TRACKER_CORE_MACROS_SVH
`define TLV_NESTING_LEVEL_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define TLV_NLT_ASSERT_NOW(name, ck, rn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TLV_NLT_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/tlv_nlt_pkg.sv
// ----------------------------------------------------------------------------
// TLV nesting level tracker - package
// Sizes, codes and the beat types shared by controller, datapath and top.
// ----------------------------------------------------------------------------
`default_nettype none

package tlv_nlt_pkg;

	localparam int MAX_DEPTH   = 32;
	localparam int LENGTH_BITS = 32;

	localparam int DEPTH_W = $clog2(MAX_DEPTH);
	localparam int REM_W   = LENGTH_BITS + 1;
	localparam int SUB_W   = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 3;
	localparam int CNT_W   = 5;

	localparam logic [1:0] CMD_PRIM = 2'd0;
	localparam logic [1:0] CMD_CONS = 2'd1;
	localparam logic [1:0] CMD_EOC  = 2'd2;
	localparam logic [1:0] CMD_EOI  = 2'd3;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_ELEM_OVER = 2'd1;
	localparam logic [1:0] STAT_CONS_OVER = 2'd2;
	localparam logic [1:0] STAT_DEPTH_OVF = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] header_bytes;
		logic [31:0] body_length;
		logic        indefinite;
	} desc_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] depth;
		logic [CNT_W-1:0] levels_closed;
		logic [31:0]      missing_bytes;
		logic [CNT_W-1:0] missing_eoc;
	} res_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic pop;
		logic scan;
		logic publish;
	} dp_cmd_t;

	typedef struct packed {
		logic is_eoi;
		logic pop_needed;
		logic scan_done;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> design/tlv_nesting_level_tracker_core.sv
// ----------------------------------------------------------------------------
// TLV nesting level tracker - top level
// Follows nesting depth and remaining sizes of a tag-length-value stream.
// ----------------------------------------------------------------------------
// Usage:
//   desc channel (desc_valid/desc_stall/desc) carries one element descriptor
//   per beat; res channel (res_valid/res_stall/res) returns one result beat
//   per descriptor, in order.
//   A descriptor is taken at a clock edge with desc_valid high and desc_stall
//   low. The block works on one descriptor at a time; desc_stall is high
//   from the accepting edge until the result is in the output register.
//   Sequence: after acceptance the step executes, then the pop cascade closes
//   levels, one level per cycle, until no level needs closing, and the
//   result waits for the output register; end of input instead scans the
//   open levels, one per cycle, down to the top level.
//   The level lanes are all updated together in the execute step; a new
//   descriptor is taken only once the previous one has been handed off.
//   The output register frees the input side: a new descriptor is taken
//   while the previous result still waits under res_stall. A finished result
//   holds in the datapath until the output register frees.
//   arst_n clears the depth to the top level, all indefinite marks and
//   res_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_nesting_level_tracker_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               desc_valid,
	output logic                    desc_stall,
	input  wire tlv_nlt_pkg::desc_t desc,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output tlv_nlt_pkg::res_t       res
);

	tlv_nlt_pkg::dp_cmd_t  cmd;
	tlv_nlt_pkg::dp_stat_t stat;

	tlv_nlt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc_stall (desc_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	tlv_nlt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc      (desc),
		.cmd       (cmd),
		.res_stall (res_stall),
		.stat      (stat),
		.res       (res),
		.res_valid (res_valid)
	);

endmodule

`default_nettype wire

>>> design/tlv_nlt_ctrl.sv
// ----------------------------------------------------------------------------
// TLV nesting level tracker - controller
// Sequences capture, step execution, cascaded pops, end-of-input scan and
// result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_nlt_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  desc_valid,
	output logic                       desc_stall,
	input  wire tlv_nlt_pkg::dp_stat_t stat,
	output tlv_nlt_pkg::dp_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_POP  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign desc_stall = (state_q != S_IDLE);

	always_comb begin
		cmd.load    = (state_q == S_IDLE) && desc_valid;
		cmd.exec    = (state_q == S_EXEC);
		cmd.pop     = (state_q == S_POP) && stat.pop_needed;
		cmd.scan    = (state_q == S_SCAN);
		cmd.publish = (state_q == S_DONE) && stat.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (desc_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = stat.is_eoi ? S_SCAN : S_POP;
			end
			S_POP: begin
				if (!stat.pop_needed) state_d = S_DONE;
			end
			S_SCAN: begin
				if (stat.scan_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> design/tlv_nlt_dp.sv
// ----------------------------------------------------------------------------
// TLV nesting level tracker - datapath
// Per-level remaining-size lanes, level pointer, result counters and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tlv_nesting_level_tracker_core_macros.svh"

module tlv_nlt_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tlv_nlt_pkg::desc_t   desc,
	input  wire tlv_nlt_pkg::dp_cmd_t cmd,
	input  wire logic                 res_stall,
	output tlv_nlt_pkg::dp_stat_t     stat,
	output tlv_nlt_pkg::res_t         res,
	output logic                      res_valid
);

	localparam int MAX_DEPTH = tlv_nlt_pkg::MAX_DEPTH;
	localparam int DEPTH_W   = tlv_nlt_pkg::DEPTH_W;
	localparam int REM_W     = tlv_nlt_pkg::REM_W;
	localparam int SUB_W     = tlv_nlt_pkg::SUB_W;
	localparam int CNT_W     = tlv_nlt_pkg::CNT_W;

	localparam logic signed [SUB_W-1:0] REM_MAX_W =
		(SUB_W'(1) << tlv_nlt_pkg::LENGTH_BITS) - SUB_W'(1);
	localparam logic signed [SUB_W-1:0] REM_MIN_W = ~REM_MAX_W;
	localparam logic signed [SUB_W-1:0] U32_MAX_W = SUB_W'(32'hFFFF_FFFF);

	tlv_nlt_pkg::desc_t desc_q;

	logic signed [REM_W-1:0] rem_q [MAX_DEPTH];
	logic [MAX_DEPTH-1:0]    indef_q;
	logic [DEPTH_W-1:0]      depth_q;
	logic [DEPTH_W-1:0]      closed_q;
	logic [DEPTH_W-1:0]      eoc_q;
	logic [31:0]             mb_q;
	logic [1:0]              status_q;
	tlv_nlt_pkg::res_t       res_q;
	logic                    res_valid_q;

	logic signed [REM_W-1:0] rem_rd;
	logic signed [SUB_W-1:0] rd_wide;
	logic signed [SUB_W-1:0] hdr_wide;
	logic signed [SUB_W-1:0] body_wide;
	logic signed [SUB_W-1:0] cur;
	logic signed [SUB_W-1:0] amt;
	logic signed [SUB_W-1:0] push_wide;
	logic signed [SUB_W-1:0] lane_diff [MAX_DEPTH];
	logic signed [REM_W-1:0] lane_next [MAX_DEPTH];
	logic [DEPTH_W-1:0]      depth_inc;
	logic [DEPTH_W-1:0]      depth_dec;
	logic                    parent_def;
	logic                    too_big;
	logic                    rem_pos;
	logic                    eoc_closes;
	logic [1:0]              exec_status;
	logic [31:0]             mb_sat;

	assign rem_rd    = rem_q[depth_q];
	assign rd_wide   = {{(SUB_W-REM_W){rem_rd[REM_W-1]}}, rem_rd};
	assign hdr_wide  = SUB_W'(desc_q.header_bytes);
	assign body_wide = SUB_W'(desc_q.body_length);
	assign cur       = rd_wide - hdr_wide;
	assign depth_inc = depth_q + DEPTH_W'(1);
	assign depth_dec = depth_q - DEPTH_W'(1);

	assign parent_def = (depth_q != '0) && !indef_q[depth_q];
	assign too_big    = parent_def && (cur < body_wide);
	assign rem_pos    = !rem_rd[REM_W-1] && (rem_rd != '0);
	assign eoc_closes = (depth_q != '0) && indef_q[depth_q];
	assign mb_sat     = (rd_wide > U32_MAX_W) ? 32'hFFFF_FFFF : rd_wide[31:0];
	assign push_wide  = (body_wide > REM_MAX_W) ? REM_MAX_W : body_wide;
	assign amt        = hdr_wide + ((desc_q.cmd == tlv_nlt_pkg::CMD_PRIM) ? body_wide : '0);

	always_comb begin
		case (desc_q.cmd)
			tlv_nlt_pkg::CMD_PRIM: begin
				exec_status = too_big ? tlv_nlt_pkg::STAT_ELEM_OVER : tlv_nlt_pkg::STAT_OK;
			end
			tlv_nlt_pkg::CMD_CONS: begin
				if (too_big) begin
					exec_status = tlv_nlt_pkg::STAT_CONS_OVER;
				end else if (depth_q == DEPTH_W'(MAX_DEPTH - 1)) begin
					exec_status = tlv_nlt_pkg::STAT_DEPTH_OVF;
				end else begin
					exec_status = tlv_nlt_pkg::STAT_OK;
				end
			end
			default: begin
				exec_status = tlv_nlt_pkg::STAT_OK;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < MAX_DEPTH; i++) begin
			lane_diff[i] = {{(SUB_W-REM_W){rem_q[i][REM_W-1]}}, rem_q[i]} - amt;
			lane_next[i] = (lane_diff[i] < REM_MIN_W) ? REM_MIN_W[REM_W-1:0]
				: lane_diff[i][REM_W-1:0];
		end
	end

	always_comb begin
		stat.is_eoi     = (desc_q.cmd == tlv_nlt_pkg::CMD_EOI);
		stat.pop_needed = (status_q == tlv_nlt_pkg::STAT_OK) && parent_def && !rem_pos;
		stat.scan_done  = (depth_q == '0);
		stat.out_free   = !res_valid_q || !res_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			indef_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.exec && (exec_status == tlv_nlt_pkg::STAT_OK)) begin
				case (desc_q.cmd)
					tlv_nlt_pkg::CMD_CONS: begin
						depth_q            <= depth_inc;
						indef_q[depth_inc] <= desc_q.indefinite;
					end
					tlv_nlt_pkg::CMD_EOC: begin
						if (eoc_closes) depth_q <= depth_dec;
					end
					default: begin
					end
				endcase
			end
			if (cmd.pop) begin
				depth_q <= depth_dec;
			end
			if (cmd.scan) begin
				if (depth_q == '0) begin
					indef_q <= '0;
				end else begin
					depth_q <= depth_dec;
				end
			end
			if (cmd.publish) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			desc_q <= desc;
		end
		if (cmd.exec) begin
			status_q <= exec_status;
			eoc_q    <= '0;
			mb_q     <= '0;
			if (desc_q.cmd == tlv_nlt_pkg::CMD_EOI) begin
				closed_q <= depth_q;
			end else if ((desc_q.cmd == tlv_nlt_pkg::CMD_EOC) && eoc_closes) begin
				closed_q <= DEPTH_W'(1);
			end else begin
				closed_q <= '0;
			end
			if ((exec_status == tlv_nlt_pkg::STAT_OK) &&
				(desc_q.cmd != tlv_nlt_pkg::CMD_EOI)) begin
				for (int i = 0; i < MAX_DEPTH; i++) begin
					if ((desc_q.cmd == tlv_nlt_pkg::CMD_CONS) &&
						(DEPTH_W'(i) == depth_inc)) begin
						rem_q[i] <= push_wide[REM_W-1:0];
					end else begin
						rem_q[i] <= lane_next[i];
					end
				end
			end
		end
		if (cmd.pop) begin
			closed_q <= closed_q + DEPTH_W'(1);
		end
		if (cmd.scan && (depth_q != '0)) begin
			if (indef_q[depth_q]) begin
				eoc_q <= eoc_q + DEPTH_W'(1);
			end else if (rem_pos) begin
				mb_q <= mb_sat;
			end
		end
		if (cmd.publish) begin
			res_q.status        <= status_q;
			res_q.depth         <= CNT_W'(depth_q);
			res_q.levels_closed <= CNT_W'(closed_q);
			res_q.missing_bytes <= mb_q;
			res_q.missing_eoc   <= CNT_W'(eoc_q);
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

	`TLV_NLT_ASSERT_NEXT(a_pop_steps_down, clk, arst_n, cmd.pop, depth_q == $past(depth_q) - DEPTH_W'(1), "pop did not lower depth by one")
	`TLV_NLT_ASSERT_NOW(a_pop_not_top, clk, arst_n, cmd.pop, depth_q != '0, "pop requested at top level")
	`TLV_NLT_ASSERT_NEXT(a_error_holds_depth, clk, arst_n, cmd.exec && (exec_status != tlv_nlt_pkg::STAT_OK), depth_q == $past(depth_q), "rejected element changed depth")
	`TLV_NLT_ASSERT_NOW(a_error_closes_none, clk, arst_n, cmd.publish && (status_q != tlv_nlt_pkg::STAT_OK), closed_q == '0, "rejected element reports closed levels")

endmodule

`default_nettype wire
